// ----- rtl/core/brts_pkg.sv -----
// ----------------------------------------------------------------------------
// brts_pkg
// Shared constants, operation codes and controller/datapath interface types
// for the bilinear RGBA table sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package brts_pkg;

  // Table geometry and channel format
  localparam int unsigned MAX_COLUMNS  = 256;
  localparam int unsigned MAX_ROWS     = 256;
  localparam int unsigned CHANNEL_BITS = 8;
  localparam int unsigned NUM_CHANNELS = 4;

  localparam int unsigned COL_W    = $clog2(MAX_COLUMNS);
  localparam int unsigned ROW_W    = $clog2(MAX_ROWS);
  localparam int unsigned COL_SZ_W = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned ROW_SZ_W = $clog2(MAX_ROWS + 1);
  localparam int unsigned MEM_DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
  localparam int unsigned TEXEL_W   = NUM_CHANNELS * CHANNEL_BITS;

  // Port widths fixed by the interface
  localparam int unsigned OP_W      = 2;
  localparam int unsigned IDX_IN_W  = 8;
  localparam int unsigned CODE_IN_W = 8;
  localparam int unsigned POS_W     = 17;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned CFG_IDX_W = 1;

  // Fixed-point layout
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned OUT_FRAC = OUT_W - CHANNEL_BITS;
  localparam int unsigned SX_W     = FRAC_W + COL_W;
  localparam int unsigned SY_W     = FRAC_W + ROW_W;
  localparam int unsigned AB_W     = CHANNEL_BITS + FRAC_W;
  localparam int unsigned V_W      = CHANNEL_BITS + 2 * FRAC_W;

  localparam logic [POS_W-1:0] POS_ONE   = POS_W'(1) << FRAC_W;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);

  // Operation codes
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic       latch;      // capture the input item
    logic       prep;       // register scaled sample positions
    logic       wr_en;      // texel write (gated by index check)
    logic       rd_en;      // table read
    logic       fetch;      // read address from sample neighbours
    logic [1:0] fetch_idx;  // bit 0: ceil column, bit 1: ceil row
    logic       clr_start;  // reset the clear sweep counters
    logic       clr_en;     // write one texel of the clear sweep
    logic       lerp_x;
    logic       lerp_y;
    logic       load_out;   // load the result register
  } brts_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            clr_last;
  } brts_status_t;

  function automatic logic [ADDR_W-1:0] texel_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(c));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/brts_ctrl.sv -----
// ----------------------------------------------------------------------------
// brts_ctrl
// Sequencer for the table sampler: accepts one item, steps the datapath
// through its operation and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module brts_ctrl import brts_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output brts_cmd_t         cmd_o,
  input  wire brts_status_t status_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_LERPX = 3'd4;
  localparam logic [2:0] S_LERPY = 3'd5;
  localparam logic [2:0] S_CLEAR = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_q, state_d;
  logic [1:0] fetch_idx_q, fetch_idx_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    fetch_idx_d = fetch_idx_q;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_PREP;
        end
      end
      S_PREP: begin
        unique case (status_i.op)
          OP_WRITE: begin
            cmd_o.wr_en = 1'b1;
            state_d     = S_DONE;
          end
          OP_READ: begin
            cmd_o.rd_en = 1'b1;
            state_d     = S_DONE;
          end
          OP_SAMPLE: begin
            cmd_o.prep  = 1'b1;
            fetch_idx_d = '0;
            state_d     = S_FETCH;
          end
          OP_CLEAR: begin
            cmd_o.clr_start = 1'b1;
            state_d         = S_CLEAR;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_FETCH: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.fetch     = 1'b1;
        cmd_o.fetch_idx = fetch_idx_q;
        fetch_idx_d     = fetch_idx_q + 2'd1;
        if (fetch_idx_q == 2'd3) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = S_LERPX;
      S_LERPX: begin
        cmd_o.lerp_x = 1'b1;
        state_d      = S_LERPY;
      end
      S_LERPY: begin
        cmd_o.lerp_y = 1'b1;
        state_d      = S_DONE;
      end
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fetch_idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fetch_idx_q <= fetch_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/brts_datapath.sv -----
// ----------------------------------------------------------------------------
// brts_datapath
// Size registers, texel table memory, neighbour capture, the two lerp
// stages and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module brts_datapath import brts_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic [OP_W-1:0]      operation_i,
  input  wire logic [IDX_IN_W-1:0]  column_i,
  input  wire logic [IDX_IN_W-1:0]  row_i,
  input  wire logic [CODE_IN_W-1:0] chan_r_i,
  input  wire logic [CODE_IN_W-1:0] chan_g_i,
  input  wire logic [CODE_IN_W-1:0] chan_b_i,
  input  wire logic [CODE_IN_W-1:0] chan_a_i,
  input  wire logic [POS_W-1:0]     sample_x_i,
  input  wire logic [POS_W-1:0]     sample_y_i,
  input  wire brts_cmd_t            cmd_i,
  output brts_status_t              status_o,
  output logic [OUT_W-1:0]          out_r_o,
  output logic [OUT_W-1:0]          out_g_o,
  output logic [OUT_W-1:0]          out_b_o,
  output logic [OUT_W-1:0]          out_a_o,
  output logic                      index_error_o
);

  // Size registers
  logic [CFG_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_RESET;
      height_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [COL_SZ_W-1:0] w_eff;
  logic [ROW_SZ_W-1:0] h_eff;
  logic [COL_W-1:0]    wm1;
  logic [ROW_W-1:0]    hm1;

  // zero acts as one, oversize saturates
  always_comb begin
    if (width_q == '0) begin
      w_eff = COL_SZ_W'(1);
    end else if (32'(width_q) > MAX_COLUMNS) begin
      w_eff = COL_SZ_W'(MAX_COLUMNS);
    end else begin
      w_eff = COL_SZ_W'(width_q);
    end
    if (height_q == '0) begin
      h_eff = ROW_SZ_W'(1);
    end else if (32'(height_q) > MAX_ROWS) begin
      h_eff = ROW_SZ_W'(MAX_ROWS);
    end else begin
      h_eff = ROW_SZ_W'(height_q);
    end
  end

  assign wm1 = COL_W'(w_eff - COL_SZ_W'(1));
  assign hm1 = ROW_W'(h_eff - ROW_SZ_W'(1));

  // Input item
  logic [OP_W-1:0]     op_q;
  logic [IDX_IN_W-1:0] col_q, row_q;
  logic [TEXEL_W-1:0]  texel_q, texel_in;
  logic [POS_W-1:0]    px_q, py_q;

  assign texel_in[0*CHANNEL_BITS +: CHANNEL_BITS] = CHANNEL_BITS'(chan_r_i);
  assign texel_in[1*CHANNEL_BITS +: CHANNEL_BITS] = CHANNEL_BITS'(chan_g_i);
  assign texel_in[2*CHANNEL_BITS +: CHANNEL_BITS] = CHANNEL_BITS'(chan_b_i);
  assign texel_in[3*CHANNEL_BITS +: CHANNEL_BITS] = CHANNEL_BITS'(chan_a_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q    <= operation_i;
      col_q   <= column_i;
      row_q   <= row_i;
      texel_q <= texel_in;
      px_q    <= sample_x_i;
      py_q    <= sample_y_i;
    end
  end

  logic idx_err;
  assign idx_err = (COL_SZ_W'(col_q) >= w_eff) || (ROW_SZ_W'(row_q) >= h_eff);

  // Scaled sample positions
  logic [POS_W-1:0] px_sat, py_sat;
  logic [SX_W-1:0]  sx_q;
  logic [SY_W-1:0]  sy_q;

  assign px_sat = (px_q > POS_ONE) ? POS_ONE : px_q;
  assign py_sat = (py_q > POS_ONE) ? POS_ONE : py_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      sx_q <= SX_W'(px_sat) * SX_W'(wm1);
      sy_q <= SY_W'(py_sat) * SY_W'(hm1);
    end
  end

  logic [COL_W-1:0]  x0, x1;
  logic [ROW_W-1:0]  y0, y1;
  logic [FRAC_W-1:0] fx, fy;
  logic [POS_W-1:0]  wx0, wy0;

  assign x0  = sx_q[SX_W-1:FRAC_W];
  assign fx  = sx_q[FRAC_W-1:0];
  assign y0  = sy_q[SY_W-1:FRAC_W];
  assign fy  = sy_q[FRAC_W-1:0];
  // ceil neighbour equals floor on an exact position or at the last index
  assign x1  = (fx != '0 && x0 != wm1) ? COL_W'(x0 + COL_W'(1)) : x0;
  assign y1  = (fy != '0 && y0 != hm1) ? ROW_W'(y0 + ROW_W'(1)) : y0;
  assign wx0 = POS_ONE - POS_W'(fx);
  assign wy0 = POS_ONE - POS_W'(fy);

  // Clear sweep
  logic [COL_W-1:0] ccol_q;
  logic [ROW_W-1:0] crow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ccol_q <= '0;
      crow_q <= '0;
    end else if (cmd_i.clr_start) begin
      ccol_q <= '0;
      crow_q <= '0;
    end else if (cmd_i.clr_en) begin
      if (ccol_q == wm1) begin
        ccol_q <= '0;
        crow_q <= crow_q + ROW_W'(1);
      end else begin
        ccol_q <= ccol_q + COL_W'(1);
      end
    end
  end

  assign status_o.op       = op_q;
  assign status_o.clr_last = (ccol_q == wm1) && (crow_q == hm1);

  // Texel table, single port
  logic [ADDR_W-1:0]  mem_addr;
  logic               mem_we;
  logic [TEXEL_W-1:0] rdata_q;
  logic [TEXEL_W-1:0] texel_mem_q [MEM_DEPTH];

  always_comb begin
    priority if (cmd_i.clr_en) begin
      mem_addr = texel_addr(crow_q, ccol_q);
    end else if (cmd_i.fetch) begin
      mem_addr = texel_addr(cmd_i.fetch_idx[1] ? y1 : y0, cmd_i.fetch_idx[0] ? x1 : x0);
    end else begin
      mem_addr = texel_addr(ROW_W'(row_q), COL_W'(col_q));
    end
  end

  assign mem_we = (cmd_i.wr_en && !idx_err) || cmd_i.clr_en;

  always_ff @(posedge clk_i) begin
    if (mem_we) texel_mem_q[mem_addr] <= texel_q;
    if (cmd_i.rd_en) rdata_q <= texel_mem_q[mem_addr];
  end

  // Neighbour capture, registered behind the read data
  logic               cap_valid_q;
  logic [1:0]         cap_idx_q;
  logic [TEXEL_W-1:0] nbr_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_valid_q <= 1'b0;
      cap_idx_q   <= '0;
    end else begin
      cap_valid_q <= cmd_i.rd_en && cmd_i.fetch;
      cap_idx_q   <= cmd_i.fetch_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_valid_q) nbr_q[cap_idx_q] <= rdata_q;
  end

  // Lerp stages, one lane per channel
  logic [AB_W-1:0]  ab_d [NUM_CHANNELS];
  logic [AB_W-1:0]  cd_d [NUM_CHANNELS];
  logic [AB_W-1:0]  ab_q [NUM_CHANNELS];
  logic [AB_W-1:0]  cd_q [NUM_CHANNELS];
  logic [V_W-1:0]   v_d  [NUM_CHANNELS];
  logic [V_W-1:0]   v_q  [NUM_CHANNELS];

  always_comb begin
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      ab_d[k] = AB_W'(nbr_q[0][k*CHANNEL_BITS +: CHANNEL_BITS]) * AB_W'(wx0)
              + AB_W'(nbr_q[1][k*CHANNEL_BITS +: CHANNEL_BITS]) * AB_W'(fx);
      cd_d[k] = AB_W'(nbr_q[2][k*CHANNEL_BITS +: CHANNEL_BITS]) * AB_W'(wx0)
              + AB_W'(nbr_q[3][k*CHANNEL_BITS +: CHANNEL_BITS]) * AB_W'(fx);
      v_d[k]  = V_W'(ab_q[k]) * V_W'(wy0) + V_W'(cd_q[k]) * V_W'(fy);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      if (cmd_i.lerp_x) begin
        ab_q[k] <= ab_d[k];
        cd_q[k] <= cd_d[k];
      end
      if (cmd_i.lerp_y) v_q[k] <= v_d[k];
    end
  end

  // Result register
  logic [OUT_W-1:0] res_ch [NUM_CHANNELS];
  logic             res_err;
  logic [OUT_W-1:0] out_ch_q [NUM_CHANNELS];
  logic             out_err_q;

  always_comb begin
    res_err = 1'b0;
    for (int k = 0; k < NUM_CHANNELS; k++) res_ch[k] = '0;
    unique case (op_q)
      OP_WRITE: res_err = idx_err;
      OP_READ: begin
        res_err = idx_err;
        if (!idx_err) begin
          for (int k = 0; k < NUM_CHANNELS; k++) begin
            res_ch[k] = OUT_W'(OUT_W'(rdata_q[k*CHANNEL_BITS +: CHANNEL_BITS]) << OUT_FRAC);
          end
        end
      end
      OP_SAMPLE: begin
        for (int k = 0; k < NUM_CHANNELS; k++) begin
          res_ch[k] = v_q[k][V_W-1 -: OUT_W];
        end
      end
      OP_CLEAR: res_err = 1'b0;
      default: res_err = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_ch_q  <= res_ch;
      out_err_q <= res_err;
    end
  end

  assign out_r_o       = out_ch_q[0];
  assign out_g_o       = out_ch_q[1];
  assign out_b_o       = out_ch_q[2];
  assign out_a_o       = out_ch_q[3];
  assign index_error_o = out_err_q;

endmodule

`default_nettype wire

// ----- rtl/core/bilinear_rgba_table_sampler.sv -----
// ----------------------------------------------------------------------------
// bilinear_rgba_table_sampler
// RGBA8 texel table with write, read, clear and bilinear sample operations.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one operation per
//   transfer; every transfer yields exactly one result transfer on the
//   output channel (out_valid_o / out_stall_i). One item is in work at a
//   time; in_stall_o is high from the cycle after a transfer until the
//   result is loaded into the output register.
//   A bilinear sample makes four reads from the single-port table memory,
//   then passes an x lerp stage and a y lerp stage; a clear writes one
//   texel per cycle over width * height entries.
//   The output register holds a result while out_stall_i is high; the next
//   item may be taken meanwhile and waits in its last step for the slot.
//   Reset sets both size registers to 256 and empties the pipeline; the
//   table contents are undefined until written or cleared. Size registers
//   are written through cfg_we_i / cfg_index_i / cfg_data_i; the user must
//   write them only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_rgba_table_sampler import brts_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [OP_W-1:0]      operation_i,
  input  wire logic [IDX_IN_W-1:0]  column_i,
  input  wire logic [IDX_IN_W-1:0]  row_i,
  input  wire logic [CODE_IN_W-1:0] chan_r_i,
  input  wire logic [CODE_IN_W-1:0] chan_g_i,
  input  wire logic [CODE_IN_W-1:0] chan_b_i,
  input  wire logic [CODE_IN_W-1:0] chan_a_i,
  input  wire logic [POS_W-1:0]     sample_x_i,
  input  wire logic [POS_W-1:0]     sample_y_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [OUT_W-1:0]          out_r_o,
  output logic [OUT_W-1:0]          out_g_o,
  output logic [OUT_W-1:0]          out_b_o,
  output logic [OUT_W-1:0]          out_a_o,
  output logic                      index_error_o
);

  brts_cmd_t    cmd;
  brts_status_t status;

  brts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  brts_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .operation_i   (operation_i),
    .column_i      (column_i),
    .row_i         (row_i),
    .chan_r_i      (chan_r_i),
    .chan_g_i      (chan_g_i),
    .chan_b_i      (chan_b_i),
    .chan_a_i      (chan_a_i),
    .sample_x_i    (sample_x_i),
    .sample_y_i    (sample_y_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_r_o       (out_r_o),
    .out_g_o       (out_g_o),
    .out_b_o       (out_b_o),
    .out_a_o       (out_a_o),
    .index_error_o (index_error_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/brts_checker.sv -----
// ----------------------------------------------------------------------------
// brts_checker
// Port-level checks for the table sampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module brts_checker import brts_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic [OUT_W-1:0] out_r_o,
  input wire logic [OUT_W-1:0] out_g_o,
  input wire logic [OUT_W-1:0] out_b_o,
  input wire logic [OUT_W-1:0] out_a_o,
  input wire logic             index_error_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_r_o) && $stable(out_g_o)
                                   && $stable(out_b_o) && $stable(out_a_o)
                                   && $stable(index_error_o))
    else $error("stalled result changed");

  // one item in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");

  // a flagged index gives zero channels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && index_error_o |-> out_r_o == '0 && out_g_o == '0
                                     && out_b_o == '0 && out_a_o == '0)
    else $error("index error with nonzero channels");

endmodule

bind bilinear_rgba_table_sampler brts_checker u_brts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_r_o       (out_r_o),
  .out_g_o       (out_g_o),
  .out_b_o       (out_b_o),
  .out_a_o       (out_a_o),
  .index_error_o (index_error_o)
);

`default_nettype wire

// ----- dv/brts_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// brts_tb_pkg
// Transfer types and scoreboard for the bilinear RGBA table sampler bench.
// The scoreboard mirrors the texel table and the size registers, predicts one
// result per accepted operation and checks result transfers in order.
// ----------------------------------------------------------------------------
package brts_tb_pkg;
  import brts_pkg::*;

  typedef bit [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] texel_t;

  // index 0 = red ... index 3 = alpha
  typedef struct {
    logic [OP_W-1:0]                         op;
    logic [IDX_IN_W-1:0]                     col;
    logic [IDX_IN_W-1:0]                     row;
    logic [NUM_CHANNELS-1:0][CODE_IN_W-1:0]  code;
    logic [POS_W-1:0]                        sx;
    logic [POS_W-1:0]                        sy;
  } op_item_t;

  typedef struct {
    logic [NUM_CHANNELS-1:0][OUT_W-1:0] ch;
    logic                               idx_err;
  } texel_result_t;

  class rgba_table_scoreboard;
    texel_t           texel_store [MEM_DEPTH];
    logic [CFG_W-1:0] width_reg  = CFG_RESET;
    logic [CFG_W-1:0] height_reg = CFG_RESET;
    texel_result_t    expected_texels [$];
    int unsigned      failures = 0;
    string            chan_name [NUM_CHANNELS] = '{"red", "green", "blue", "alpha"};

    // zero acts as one, oversize saturates
    function int unsigned in_use(input logic [CFG_W-1:0] size_reg,
                                 input int unsigned limit);
      if (size_reg == 0) return 1;
      return (size_reg > limit) ? limit : int'(size_reg);
    endfunction

    function int unsigned cols();
      return in_use(width_reg, MAX_COLUMNS);
    endfunction

    function int unsigned rows();
      return in_use(height_reg, MAX_ROWS);
    endfunction

    function int unsigned outstanding();
      return expected_texels.size();
    endfunction

    function void write_size(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] value);
      if (idx == CFG_WIDTH) width_reg = value;
      else height_reg = value;
    endfunction

    function void split_pos(input logic [POS_W-1:0] pos, input int unsigned size,
                            output int unsigned lo, output int unsigned hi,
                            output int unsigned frac);
      int unsigned p;
      int unsigned s;
      p = (pos > POS_ONE) ? int'(POS_ONE) : int'(pos);
      s = p * (size - 1);
      lo = s >> FRAC_W;
      frac = s & 32'hFFFF;
      hi = (frac != 0) ? lo + 1 : lo;
      if (hi > size - 1) hi = size - 1;
    endfunction

    function void accept_op(input op_item_t it);
      texel_result_t   res;
      int unsigned     w, h, x0, x1, fx, y0, y1, fy;
      texel_t          t00, t10, t01, t11, t;
      longint unsigned upper, lower, mix;
      w = cols();
      h = rows();
      res.ch = '0;
      res.idx_err = 1'b0;
      case (it.op)
        OP_WRITE, OP_READ: begin
          if (it.col >= w || it.row >= h) begin
            res.idx_err = 1'b1;
          end else if (it.op == OP_WRITE) begin
            texel_store[it.row * MAX_COLUMNS + it.col] = it.code;
          end else begin
            t = texel_store[it.row * MAX_COLUMNS + it.col];
            for (int k = 0; k < NUM_CHANNELS; k++) res.ch[k] = OUT_W'(t[k]) << OUT_FRAC;
          end
        end
        OP_CLEAR: begin
          for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++) texel_store[r * MAX_COLUMNS + c] = it.code;
        end
        default: begin
          split_pos(it.sx, w, x0, x1, fx);
          split_pos(it.sy, h, y0, y1, fy);
          t00 = texel_store[y0 * MAX_COLUMNS + x0];
          t10 = texel_store[y0 * MAX_COLUMNS + x1];
          t01 = texel_store[y1 * MAX_COLUMNS + x0];
          t11 = texel_store[y1 * MAX_COLUMNS + x1];
          // both lerps at full precision, one truncation at the end
          for (int k = 0; k < NUM_CHANNELS; k++) begin
            upper = 64'(t00[k]) * (POS_ONE - fx) + 64'(t10[k]) * fx;
            lower = 64'(t01[k]) * (POS_ONE - fx) + 64'(t11[k]) * fx;
            mix = upper * (POS_ONE - fy) + lower * fy;
            res.ch[k] = OUT_W'(mix >> (2 * FRAC_W - OUT_FRAC));
          end
        end
      endcase
      expected_texels.push_back(res);
    endfunction

    task report_mismatch(input string msg);
      failures++;
      if (failures <= 50) $display("%0t ERROR %s", $time, msg);
    endtask

    task check_result(input texel_result_t got);
      texel_result_t want;
      if (expected_texels.size() == 0) begin
        report_mismatch("result transfer with no operation pending");
        return;
      end
      want = expected_texels.pop_front();
      for (int k = 0; k < NUM_CHANNELS; k++)
        if (got.ch[k] !== want.ch[k])
          report_mismatch($sformatf("%s: got %h, expected %h",
                                    chan_name[k], got.ch[k], want.ch[k]));
      if (got.idx_err !== want.idx_err)
        report_mismatch($sformatf("index_error: got %b, expected %b",
                                  got.idx_err, want.idx_err));
    endtask
  endclass

endpackage

// ----- dv/bilinear_rgba_table_sampler_tb.sv -----
// ----------------------------------------------------------------------------
// bilinear_rgba_table_sampler_tb
// Drives write, read, clear and sample operations through a series of table
// sizes, with bursty input and a patterned output stall, and checks every
// result transfer against the scoreboard prediction.
// ----------------------------------------------------------------------------
module bilinear_rgba_table_sampler_tb;
  import brts_pkg::*;
  import brts_tb_pkg::*;

  localparam int unsigned QUIET_LIMIT = 300000;

  typedef enum int unsigned {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [OP_W-1:0]      operation_i;
  logic [IDX_IN_W-1:0]  column_i;
  logic [IDX_IN_W-1:0]  row_i;
  logic [CODE_IN_W-1:0] chan_r_i;
  logic [CODE_IN_W-1:0] chan_g_i;
  logic [CODE_IN_W-1:0] chan_b_i;
  logic [CODE_IN_W-1:0] chan_a_i;
  logic [POS_W-1:0]     sample_x_i;
  logic [POS_W-1:0]     sample_y_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [OUT_W-1:0]     out_r_o;
  logic [OUT_W-1:0]     out_g_o;
  logic [OUT_W-1:0]     out_b_o;
  logic [OUT_W-1:0]     out_a_o;
  logic                 index_error_o;

  rgba_table_scoreboard sb;
  int unsigned          burst_left = 0;
  int unsigned          quiet_cycles = 0;

  bilinear_rgba_table_sampler uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .operation_i, .column_i, .row_i,
    .chan_r_i, .chan_g_i, .chan_b_i, .chan_a_i, .sample_x_i, .sample_y_i,
    .out_valid_o, .out_stall_i, .out_r_o, .out_g_o, .out_b_o, .out_a_o,
    .index_error_o
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---- monitors, sampled at the rising edge ----
  always @(posedge clk_i) begin : watch_input
    op_item_t seen;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      seen.op   = operation_i;
      seen.col  = column_i;
      seen.row  = row_i;
      seen.code = {chan_a_i, chan_b_i, chan_g_i, chan_r_i};
      seen.sx   = sample_x_i;
      seen.sy   = sample_y_i;
      sb.accept_op(seen);
    end
  end

  always @(posedge clk_i) begin : watch_output
    texel_result_t seen;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.ch      = {out_a_o, out_b_o, out_g_o, out_r_o};
      seen.idx_err = index_error_o;
      sb.check_result(seen);
    end
  end

  // a clear of the full table is the slowest item, well under the limit
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("bilinear_rgba_table_sampler: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---- receiver stall pattern ----
  initial begin : receiver_stall
    stall_mode_e mode;
    int unsigned span;
    out_stall_i = 1'b0;
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      for (int tick = 0; tick < span; tick++) begin
        @(negedge clk_i);
        case (mode)
          STALL_NONE:  out_stall_i = 1'b0;
          STALL_LIGHT: out_stall_i = ($urandom_range(0, 99) < 30);
          STALL_HEAVY: out_stall_i = ($urandom_range(0, 99) < 80);
          default:     out_stall_i = ((tick % 11) < 6);
        endcase
      end
    end
  end

  // ---- sender ----
  // Entered and left at a falling edge; valid stays up between back-to-back items.
  task automatic send_item(input op_item_t it);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    operation_i = it.op;
    column_i    = it.col;
    row_i       = it.row;
    chan_r_i    = it.code[0];
    chan_g_i    = it.code[1];
    chan_b_i    = it.code[2];
    chan_a_i    = it.code[3];
    sample_x_i  = it.sx;
    sample_y_i  = it.sy;
    in_valid_i  = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_op(input logic [OP_W-1:0] op, input int unsigned col,
                         input int unsigned row, input logic [31:0] rgba,
                         input int unsigned sx, input int unsigned sy);
    op_item_t it;
    it.op   = op;
    it.col  = IDX_IN_W'(col);
    it.row  = IDX_IN_W'(row);
    it.code = {rgba[7:0], rgba[15:8], rgba[23:16], rgba[31:24]};
    it.sx   = POS_W'(sx);
    it.sy   = POS_W'(sy);
    send_item(it);
  endtask

  function automatic logic [POS_W-1:0] random_pos();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return POS_ONE;
      2:       return POS_W'($urandom);
      default: return POS_W'($urandom_range(0, POS_ONE));
    endcase
  endfunction

  function automatic op_item_t random_op(input int unsigned w, input int unsigned h);
    op_item_t    it;
    int unsigned pick;
    it.col  = IDX_IN_W'($urandom);
    it.row  = IDX_IN_W'($urandom);
    it.code = $urandom;
    it.sx   = random_pos();
    it.sy   = random_pos();
    pick = $urandom_range(0, 99);
    // clears only where the table area is small enough to sweep quickly
    if (pick < 30) it.op = OP_WRITE;
    else if (pick < 55) it.op = OP_READ;
    else if (pick < 92 || w * h > 4096) it.op = OP_SAMPLE;
    else it.op = OP_CLEAR;
    // mostly in-range indices, the rest probes the range check
    if ((it.op == OP_WRITE || it.op == OP_READ) && $urandom_range(0, 99) < 85) begin
      it.col = IDX_IN_W'($urandom_range(0, w - 1));
      it.row = IDX_IN_W'($urandom_range(0, h - 1));
    end
    return it;
  endfunction

  task automatic run_random(input int unsigned count);
    repeat (count) send_item(random_op(sb.cols(), sb.rows()));
  endtask

  task automatic settle(input int unsigned extra);
    in_valid_i = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.write_size(idx, value);
  endtask

  initial begin : stimulus
    int unsigned phase_cols [7];
    int unsigned phase_rows [7];
    phase_cols = '{0, 511, 2, 256, 1, 3, 16};
    phase_rows = '{0, 511, 2, 1, 256, 5, 9};
    sb = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_WIDTH;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    operation_i = OP_WRITE;
    column_i    = '0;
    row_i       = '0;
    chan_r_i    = '0;
    chan_g_i    = '0;
    chan_b_i    = '0;
    chan_a_i    = '0;
    sample_x_i  = '0;
    sample_y_i  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // full-size table: the first clear defines every entry
    send_op(OP_CLEAR,    0,   0, 32'h12345678, 0, 0);
    send_op(OP_WRITE,    0,   0, 32'hFF00FF00, 0, 0);
    send_op(OP_WRITE,  255, 255, 32'h00FF00FF, 0, 0);
    send_op(OP_WRITE,    1,   0, 32'hFFFFFFFF, 0, 0);
    send_op(OP_WRITE,    0,   1, 32'h80402010, 0, 0);
    send_op(OP_READ,     0,   0, 32'h0, 0, 0);
    send_op(OP_READ,   255, 255, 32'h0, 0, 0);
    send_op(OP_READ,     1,   0, 32'h0, 0, 0);
    send_op(OP_SAMPLE,   0,   0, 32'h0, 0, 0);
    send_op(OP_SAMPLE,   0,   0, 32'h0, 65536, 65536);
    send_op(OP_SAMPLE,   0,   0, 32'h0, 131071, 131071);
    send_op(OP_SAMPLE,   0,   0, 32'h0, 128, 200);
    send_op(OP_SAMPLE,   0,   0, 32'h0, 257, 257);
    run_random(250);

    // single-texel table: range checks and degenerate sampling
    settle(4);
    write_reg(CFG_WIDTH, CFG_W'(1));
    write_reg(CFG_HEIGHT, CFG_W'(1));
    send_op(OP_CLEAR,    0,   0, 32'hFF008001, 0, 0);
    send_op(OP_WRITE,    1,   0, 32'hAAAAAAAA, 0, 0);
    send_op(OP_READ,     0,   1, 32'h0, 0, 0);
    send_op(OP_READ,     0,   0, 32'h0, 0, 0);
    send_op(OP_WRITE,    0,   0, 32'h01020304, 0, 0);
    send_op(OP_SAMPLE,   0,   0, 32'h0, 131071, 65536);
    send_op(OP_READ,   255, 255, 32'h0, 0, 0);
    run_random(150);

    foreach (phase_cols[p]) begin
      settle(4);
      write_reg(CFG_WIDTH, CFG_W'(phase_cols[p]));
      write_reg(CFG_HEIGHT, CFG_W'(phase_rows[p]));
      run_random(180);
    end

    repeat (3) begin
      settle(4);
      write_reg(CFG_WIDTH, CFG_W'($urandom_range(0, 511)));
      write_reg(CFG_HEIGHT, CFG_W'($urandom_range(0, 511)));
      run_random(120);
    end

    settle(16);
    if (sb.failures == 0) begin
      $display("bilinear_rgba_table_sampler: match");
    end else begin
      $display("bilinear_rgba_table_sampler: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/brts_pkg.sv
rtl/core/brts_ctrl.sv
rtl/core/brts_datapath.sv
rtl/core/bilinear_rgba_table_sampler.sv
rtl/core/brts_checker.sv
dv/brts_tb_pkg.sv
dv/bilinear_rgba_table_sampler_tb.sv
